// ===== hw/rtl/crc16_frame_deframer_macros.svh =====
// Assertion macros shared by the deframer RTL files.
`ifndef CRC16_FRAME_DEFRAMER_MACROS_SVH
`define CRC16_FRAME_DEFRAMER_MACROS_SVH

`ifndef SYNTH

// Same-cycle implication, checked outside reset.
`define CRCDF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define CRCDF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`else

`define CRCDF_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define CRCDF_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

// ===== hw/rtl/crcdf_pkg.sv =====
// Shared types, codes and the CRC-16 byte update for the frame deframer.
package crcdf_pkg;

  localparam logic [7:0]  BYTE_START = 8'h02;
  localparam logic [7:0]  BYTE_END   = 8'h03;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  typedef enum logic [1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_GOOD    = 2'd1,
    KIND_CRC_BAD = 2'd2,
    KIND_END_BAD = 2'd3
  } kind_t;

  typedef struct packed {
    logic [15:0] crc_value;
    logic [7:0]  frame_length;
    logic [7:0]  index;
    logic [7:0]  data;
    kind_t       kind;
  } res_t;

  // One byte of CRC-16 (MSB first, no reflection), eight shift steps.
  function automatic logic [15:0] crc_feed(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if (c[15]) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

// ===== hw/rtl/crc16_frame_deframer.sv =====
// Top level: STX/length/payload/CRC-16/ETX frame deframer on byte streams.
//
//  Channel    Direction  Handshake            Contents
//  s_axis     in         s_tvalid / s_tready  s_tdata[7:0] rx_byte
//  m_axis     out        m_tvalid / m_tready  m_tdata data,index,frame_length,crc_value;
//                                             m_tuser kind
//
// Every accepted byte is handled in the cycle it is taken; a result is registered in
// the output register, or in the skid stage behind it. One byte per cycle is sustained
// while m_tready is high. The two-entry result buffer lets one more result enter while
// a result waits; s_tready drops only when both entries are full.
// Synchronous reset returns to hunting for the start byte and empties the buffer.
`include "crc16_frame_deframer_macros.svh"

module crc16_frame_deframer
  import crcdf_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] rx_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [39:0] m_tdata,   // [7:0] data, [15:8] index, [23:16] frame_length,
                                 // [39:24] crc_value
  output logic [1:0]  m_tuser    // [1:0] kind
);

  typedef enum logic [5:0] {
    PH_HUNT    = 6'b000001,
    PH_LEN     = 6'b000010,
    PH_PAYLOAD = 6'b000100,
    PH_CRC_HI  = 6'b001000,
    PH_CRC_LO  = 6'b010000,
    PH_END     = 6'b100000
  } phase_t;

  phase_t      phase, phase_next;
  logic [7:0]  payload_length, payload_length_next;
  logic [7:0]  payload_count, payload_count_next;
  logic [15:0] running_crc, running_crc_next;
  logic [15:0] received_crc, received_crc_next;

  logic accept;
  logic res_push;
  logic buf_ready;
  res_t res;
  res_t out_res;

  assign s_tready = buf_ready;
  assign accept   = s_tvalid && s_tready;

  always_comb begin
    phase_next          = phase;
    payload_length_next = payload_length;
    payload_count_next  = payload_count;
    running_crc_next    = running_crc;
    received_crc_next   = received_crc;
    res_push            = 1'b0;
    res                 = '0;
    res.frame_length    = payload_length;
    case (phase)
      PH_LEN: begin
        if (s_tdata == 8'h00) begin
          phase_next = PH_HUNT;
        end else begin
          payload_length_next = s_tdata;
          payload_count_next  = 8'h00;
          running_crc_next    = 16'h0000;
          phase_next          = PH_PAYLOAD;
        end
      end
      PH_PAYLOAD: begin
        res_push           = 1'b1;
        res.kind           = KIND_PAYLOAD;
        res.data           = s_tdata;
        res.index          = payload_count;
        running_crc_next   = crc_feed(running_crc, s_tdata);
        payload_count_next = payload_count + 8'd1;
        if (payload_count_next == payload_length) begin
          phase_next = PH_CRC_HI;
        end
      end
      PH_CRC_HI: begin
        received_crc_next = {s_tdata, 8'h00};
        phase_next        = PH_CRC_LO;
      end
      PH_CRC_LO: begin
        received_crc_next = {received_crc[15:8], s_tdata};
        phase_next        = PH_END;
      end
      PH_END: begin
        res_push = 1'b1;
        // A wrong end byte wins over a CRC mismatch.
        if (s_tdata != BYTE_END) begin
          res.kind = KIND_END_BAD;
        end else if (running_crc == received_crc) begin
          res.kind = KIND_GOOD;
        end else begin
          res.kind = KIND_CRC_BAD;
        end
        res.crc_value = running_crc;
        phase_next    = PH_HUNT;
      end
      default: begin
        phase_next = (s_tdata == BYTE_START) ? PH_LEN : PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_HUNT;
      payload_length <= 8'h00;
      payload_count  <= 8'h00;
      running_crc    <= 16'h0000;
      received_crc   <= 16'h0000;
    end else if (accept) begin
      phase          <= phase_next;
      payload_length <= payload_length_next;
      payload_count  <= payload_count_next;
      running_crc    <= running_crc_next;
      received_crc   <= received_crc_next;
    end
  end

  crcdf_outbuf u_outbuf (
    .clk      (clk),
    .rst      (rst),
    .in_valid (accept && res_push),
    .in_ready (buf_ready),
    .in_res   (res),
    .out_valid(m_tvalid),
    .out_ready(m_tready),
    .out_res  (out_res)
  );

  assign m_tdata = {out_res.crc_value, out_res.frame_length, out_res.index, out_res.data};
  assign m_tuser = out_res.kind;

  `CRCDF_ASSERT_IMP(a_count_in_range, clk, rst, phase == PH_PAYLOAD,
                    (payload_length != 8'h00) && (payload_count < payload_length),
                    "payload count outside frame length")
  `CRCDF_ASSERT_NXT(a_end_to_hunt, clk, rst, accept && (phase == PH_END), phase == PH_HUNT,
                    "end byte did not return to hunting")
  `CRCDF_ASSERT_NXT(a_zero_len_hunt, clk, rst,
                    accept && (phase == PH_LEN) && (s_tdata == 8'h00), phase == PH_HUNT,
                    "zero length did not return to hunting")

endmodule

// ===== hw/rtl/crcdf_outbuf.sv =====
// Two-entry result buffer: an output register with a skid stage behind it.
`include "crc16_frame_deframer_macros.svh"

module crcdf_outbuf
  import crcdf_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic in_valid,
  output logic in_ready,
  input  res_t in_res,
  output logic out_valid,
  input  logic out_ready,
  output res_t out_res
);

  logic main_valid;
  logic skid_valid;
  res_t main_res;
  res_t skid_res;

  assign in_ready  = !skid_valid;
  assign out_valid = main_valid;
  assign out_res   = main_res;

  always_ff @(posedge clk) begin
    if (rst) begin
      main_valid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (in_valid && in_ready) begin
      if (main_valid && !out_ready) begin
        skid_res   <= in_res;
        skid_valid <= 1'b1;
      end else begin
        main_res   <= in_res;
        main_valid <= 1'b1;
      end
    end else if (out_ready) begin
      if (skid_valid) begin
        main_res   <= skid_res;
        skid_valid <= 1'b0;
      end else begin
        main_valid <= 1'b0;
      end
    end
  end

  `CRCDF_ASSERT_IMP(a_skid_behind_main, clk, rst, skid_valid, main_valid, "skid full, main empty")
  `CRCDF_ASSERT_NXT(a_main_holds, clk, rst, main_valid && !out_ready, main_valid,
                    "result dropped while stalled")
  `CRCDF_ASSERT_NXT(a_skid_holds, clk, rst, skid_valid && !out_ready, skid_valid && main_valid,
                    "skid entry lost while stalled")

endmodule
